>>> rtl/core/tscb_pkg.sv
// ----------------------------------------------------------------------------
// tscb_pkg
// Types and constants shared by the sample-capture controller and datapath.
// ----------------------------------------------------------------------------
package tscb_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned FILL_W    = 6;
  localparam int unsigned PRESC_W   = 10;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned SEL_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_VALUE = 1'd1;

  localparam logic [SEL_W-1:0]    CLOCK_SELECT_RST  = 8'd1;
  localparam logic [TIMER_W-1:0]  COMPARE_VALUE_RST = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] ECHO_MARK         = 8'h44;  // 'D'

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_ECHO = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_COUNT,
    ST_READ,
    ST_SAMPLE,
    ST_ECHO_HI,
    ST_ECHO_LO,
    ST_ECHO_MARK
  } state_e;

  typedef enum logic [2:0] {
    BSEL_ZERO,
    BSEL_COUNT,
    BSEL_SAMPLE,
    BSEL_CMP_HI,
    BSEL_CMP_LO,
    BSEL_MARK
  } byte_sel_e;

  typedef struct packed {
    logic      tick_en;
    logic      clear_fill;
    logic      load_out;
    byte_sel_e sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic out_free;
  } dp_stat_t;

  // Terminal prescaler count for a clock select code (divisor minus one).
  function automatic logic [PRESC_W-1:0] presc_term(input logic [SEL_W-1:0] sel);
    logic [PRESC_W-1:0] term;
    case (sel)
      8'd1:    term = 10'd0;
      8'd2:    term = 10'd7;
      8'd3:    term = 10'd63;
      8'd4:    term = 10'd255;
      8'd5:    term = 10'd1023;
      default: term = 10'd0;
    endcase
    return term;
  endfunction

  function automatic logic presc_enabled(input logic [SEL_W-1:0] sel);
    return (sel >= 8'd1) && (sel <= 8'd5);
  endfunction

endpackage

>>> rtl/core/tscb_ctrl.sv
// ----------------------------------------------------------------------------
// tscb_ctrl
// Request sequencer: accepts words, steers ticks to the datapath and walks
// the reply bytes of data and echo requests.
// ----------------------------------------------------------------------------
module tscb_ctrl #(
  parameter int unsigned SAMPLE_DEPTH = 50,
  parameter int unsigned ADDR_W       = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [tscb_pkg::FUNC_W-1:0] in_func_i,
  output logic                        in_ready_o,
  input  tscb_pkg::dp_stat_t          stat_i,
  output tscb_pkg::dp_cmd_t           cmd_o,
  output logic [ADDR_W-1:0]           rd_addr_o
);
  import tscb_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              accept;
  func_e             func;

  assign func       = func_e'(in_func_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_addr_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '{tick_en: 1'b0, clear_fill: 1'b0, load_out: 1'b0,
                sel: BSEL_ZERO, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_TICK: cmd_o.tick_en = 1'b1;
            FUNC_DATA: begin
              if (stat_i.full) begin
                cmd_o.clear_fill = 1'b1;
                state_d          = ST_COUNT;
              end else begin
                state_d = ST_ZERO;
              end
            end
            FUNC_ECHO: state_d = ST_ECHO_HI;
            default:   state_d = ST_IDLE;  // drop unused code
          endcase
        end
      end
      ST_ZERO: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_ZERO;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_COUNT;
          idx_d          = '0;
          state_d        = ST_READ;
        end
      end
      // address is presented now, read data is registered for ST_SAMPLE
      ST_READ: state_d = ST_SAMPLE;
      ST_SAMPLE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_SAMPLE;
          cmd_o.last     = (idx_q == ADDR_W'(SAMPLE_DEPTH - 1));
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_ECHO_HI: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_CMP_HI;
          state_d        = ST_ECHO_LO;
        end
      end
      ST_ECHO_LO: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_CMP_LO;
          state_d        = ST_ECHO_MARK;
        end
      end
      ST_ECHO_MARK: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.sel      = BSEL_MARK;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_tick_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_en |-> (state_q == ST_IDLE))
    else $error("tick issued outside idle");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAMPLE) |-> (idx_q <= ADDR_W'(SAMPLE_DEPTH - 1)))
    else $error("readout index beyond store depth");

  a_read_then_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_SAMPLE))
    else $error("read slot not followed by sample slot");
`endif

endmodule

>>> rtl/core/tscb_dp.sv
// ----------------------------------------------------------------------------
// tscb_dp
// Datapath: configuration registers, prescaler, compare timer, sample store
// and the output word register.
// ----------------------------------------------------------------------------
module tscb_dp #(
  parameter int unsigned SAMPLE_DEPTH = 50,
  parameter int unsigned ADDR_W       = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tscb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tscb_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [tscb_pkg::SAMPLE_W-1:0] adc_sample_i,
  input  tscb_pkg::dp_cmd_t             cmd_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output tscb_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tscb_pkg::SAMPLE_W-1:0] out_data_o,
  output logic                          out_last_o
);
  import tscb_pkg::*;

  logic [SEL_W-1:0]    clk_sel_q, clk_sel_d;
  logic [TIMER_W-1:0]  cmp_q, cmp_d;
  logic [PRESC_W-1:0]  presc_q, presc_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                out_last_q;
  logic [SAMPLE_W-1:0] mem_q [SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic                full;
  logic                timer_clk;
  logic                match;
  logic                mem_we;

  assign full      = (fill_q == FILL_W'(SAMPLE_DEPTH));
  assign timer_clk = cmd_i.tick_en && presc_enabled(clk_sel_q)
                     && (presc_q >= presc_term(clk_sel_q));
  assign match     = timer_clk && (timer_q == cmp_q);
  assign mem_we    = match && !full;

  assign stat_o.full     = full;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    clk_sel_d = clk_sel_q;
    cmp_d     = cmp_q;
    presc_d   = presc_q;
    timer_d   = timer_q;
    fill_d    = fill_q;

    if (cmd_i.tick_en && presc_enabled(clk_sel_q)) begin
      presc_d = timer_clk ? '0 : presc_q + 1'b1;
    end
    if (timer_clk) begin
      timer_d = match ? '0 : timer_q + 1'b1;
    end
    if (mem_we) begin
      fill_d = fill_q + 1'b1;
    end
    if (cmd_i.clear_fill) begin
      fill_d = '0;
    end
    // a register write also restarts the timer
    if (cfg_we_i) begin
      timer_d = '0;
      unique case (cfg_idx_i)
        REG_CLOCK_SELECT:  clk_sel_d = cfg_data_i[SEL_W-1:0];
        REG_COMPARE_VALUE: cmp_d     = cfg_data_i[TIMER_W-1:0];
        default:           cmp_d     = cmp_q;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.sel)
      BSEL_ZERO:   out_data_d = '0;
      BSEL_COUNT:  out_data_d = SAMPLE_W'(SAMPLE_DEPTH);
      BSEL_SAMPLE: out_data_d = rdata_q;
      BSEL_CMP_HI: out_data_d = cmp_q[TIMER_W-1:SAMPLE_W];
      BSEL_CMP_LO: out_data_d = cmp_q[SAMPLE_W-1:0];
      BSEL_MARK:   out_data_d = ECHO_MARK;
      default:     out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_sel_q   <= CLOCK_SELECT_RST;
      cmp_q       <= COMPARE_VALUE_RST;
      presc_q     <= '0;
      timer_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clk_sel_q <= clk_sel_d;
      cmp_q     <= cmp_d;
      presc_q   <= presc_d;
      timer_q   <= timer_d;
      fill_q    <= fill_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= out_data_d;
      out_last_q <= cmd_i.last;
    end
  end

  // sample store: one write port at the fill position, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fill_q[ADDR_W-1:0]] <= adc_sample_i;
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before taken");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(SAMPLE_DEPTH))
    else $error("fill count beyond store depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clear_fill && !cfg_we_i) |=> (fill_q == '0))
    else $error("store not emptied after readout start");

  a_tick_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.tick_en && cmd_i.clear_fill))
    else $error("tick and store clear in same cycle");
`endif

endmodule

>>> rtl/core/timed_sample_capture_buffer_unit.sv
// ----------------------------------------------------------------------------
// timed_sample_capture_buffer_unit
// Sample-capture engine: prescaled compare timer stores ADC bytes into a
// fixed-depth buffer and answers data and echo requests as byte streams.
// ----------------------------------------------------------------------------
// Tick words are taken every cycle while idle and update timer and store in that
// cycle. A reply loads its first byte into the output register from the state
// after acceptance; a full readout then passes each sample through a registered
// store read, then the output load. Input is held off until the last reply byte
// is loaded into the output register, longer while the reply side stalls.
// Asynchronous active-low reset clears control state; the store is not cleared.
// ----------------------------------------------------------------------------
module timed_sample_capture_buffer_unit #(
  parameter int unsigned SAMPLE_DEPTH = 50
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tscb_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [7:0] adc_sample
  input  logic [tscb_pkg::FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tscb_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [7:0] data_byte
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [tscb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tscb_pkg::CFG_W-1:0]     cfg_data_i
);
  import tscb_pkg::*;

  localparam int unsigned ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [ADDR_W-1:0] rd_addr;

  tscb_ctrl #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_func_i (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  tscb_dp #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .adc_sample_i(s_axis_tdata),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/sv/timed_sample_capture_buffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_sample_capture_buffer_checker
// Watches the input, config and reply channels of the capture unit, keeps its
// own copy of prescaler, timer and sample store, and compares every reply
// word against the oldest predicted reply byte.
// ----------------------------------------------------------------------------
module timed_sample_capture_buffer_checker #(
  parameter int unsigned SAMPLE_DEPTH = 50
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tscb_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [7:0] adc_sample
  input  logic [tscb_pkg::FUNC_W-1:0]    s_axis_tuser,   // [1:0] func
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tscb_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [7:0] data_byte
  input  logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [tscb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tscb_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import tscb_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_last;
  } reply_t;

  logic [SAMPLE_W-1:0] sample_mem [SAMPLE_DEPTH];
  int unsigned         fill_level;
  int unsigned         presc_cnt;
  logic [TIMER_W-1:0]  timer_cnt;
  logic [TIMER_W-1:0]  cmp_val;
  logic [SEL_W-1:0]    sel_val;
  reply_t              reply_q [$];
  int unsigned         mismatches;

  initial begin
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int unsigned tick_divisor(input logic [SEL_W-1:0] sel);
    case (sel)
      8'd1:    return 1;
      8'd2:    return 8;
      8'd3:    return 64;
      8'd4:    return 256;
      8'd5:    return 1024;
      default: return 0;
    endcase
  endfunction

  task automatic push_reply(input logic [SAMPLE_W-1:0] value, input logic is_last);
    reply_t r;
    r.value   = value;
    r.is_last = is_last;
    reply_q.push_back(r);
  endtask

  // Advance the capture state by one input word and queue its reply bytes.
  task automatic capture_step(input logic [FUNC_W-1:0] func,
                              input logic [SAMPLE_W-1:0] adc);
    int unsigned div;
    div = tick_divisor(sel_val);
    case (func)
      FUNC_TICK: begin
        if (div != 0) begin
          if (presc_cnt + 1 >= div) begin
            presc_cnt = 0;
            if (timer_cnt == cmp_val) begin
              timer_cnt = '0;
              // drop the sample once the store is full
              if (fill_level < SAMPLE_DEPTH) begin
                sample_mem[fill_level] = adc;
                fill_level++;
              end
            end else begin
              timer_cnt = timer_cnt + 1'b1;
            end
          end else begin
            presc_cnt = presc_cnt + 1;
          end
        end
      end
      FUNC_DATA: begin
        if (fill_level != SAMPLE_DEPTH) begin
          push_reply('0, 1'b1);
        end else begin
          push_reply(SAMPLE_W'(SAMPLE_DEPTH), 1'b0);
          for (int i = 0; i < SAMPLE_DEPTH; i++) begin
            push_reply(sample_mem[i], i == SAMPLE_DEPTH - 1);
          end
          fill_level = 0;
        end
      end
      FUNC_ECHO: begin
        push_reply(cmp_val[15:8], 1'b0);
        push_reply(cmp_val[7:0], 1'b0);
        push_reply(ECHO_MARK, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (!rst_ni) begin
      fill_level = 0;
      presc_cnt  = 0;
      timer_cnt  = '0;
      cmp_val    = COMPARE_VALUE_RST;
      sel_val    = CLOCK_SELECT_RST;
      for (int i = 0; i < SAMPLE_DEPTH; i++) sample_mem[i] = '0;
      reply_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CLOCK_SELECT) begin
          sel_val   = cfg_data_i[SEL_W-1:0];
          timer_cnt = '0;
        end else if (cfg_idx_i == REG_COMPARE_VALUE) begin
          cmp_val   = cfg_data_i[TIMER_W-1:0];
          timer_cnt = '0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        capture_step(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected reply word data=%02h last=%0b",
                     $time, m_axis_tdata, m_axis_tlast);
          end
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tlast !== want.is_last) begin
            if (mismatches < 10) begin
              $display("%0t: expected data=%02h last=%0b, got data=%02h last=%0b",
                       $time, want.value, want.is_last, m_axis_tdata, m_axis_tlast);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count_o = mismatches;
    pending_o    = reply_q.size();
  end

endmodule

>>> tb/sv/timed_sample_capture_buffer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_sample_capture_buffer_unit_test
// Drives tick, data, echo and unused-code requests plus register writes into the capture
// unit, with random gaps and stalls, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module timed_sample_capture_buffer_unit_test;
  import tscb_pkg::*;

  localparam int unsigned DEPTH        = 50;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_ITEMS = 410;
  localparam int unsigned CALM_FROM    = 340;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned MAX_TICKS    = 120;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata;   // [7:0] adc_sample
  logic [FUNC_W-1:0]    s_axis_tuser;   // [1:0] func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [SAMPLE_W-1:0]  m_axis_tdata;   // [7:0] data_byte
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned random_items;
  bit          counting;
  bit          gaps_on;
  bit          calm;
  bit          long_hold;

  timed_sample_capture_buffer_unit #(
    .SAMPLE_DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  timed_sample_capture_buffer_checker #(
    .SAMPLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[timed_sample_capture_buffer_unit] ERROR");
      $finish;
    end
  end

  // Reply side: random stall bursts, plus one long hold-off on request.
  initial begin : reply_sink
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] adc);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= adc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (counting && func != FUNC_UNUSED) random_items++;
  endtask

  task automatic send_tick();
    logic [SAMPLE_W-1:0] adc;
    case ($urandom_range(0, 7))
      0:       adc = '0;
      1:       adc = '1;
      default: adc = SAMPLE_W'($urandom_range(0, 255));
    endcase
    send_item(FUNC_TICK, adc);
  endtask

  // Drop valid and hold until every reply word is back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Drop valid so that no input word is taken while a register changes.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    cfg_we_i      <= 1'b1;
    cfg_idx_i     <= idx;
    cfg_data_i    <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [SEL_W-1:0]   sel;
    logic [TIMER_W-1:0] cmp;
    int unsigned        div;
    int unsigned        n_ticks;
    int unsigned        r;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_CLOCK_SELECT;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cycle_count   = 0;
    random_items  = 0;
    counting      = 1'b0;
    gaps_on       = 1'b1;
    calm          = 1'b0;
    long_hold     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: echo of the reset compare value, request on an empty store.
    send_item(FUNC_ECHO, 8'h00);
    send_item(FUNC_DATA, 8'hFF);
    send_item(FUNC_UNUSED, 8'hFF);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_TICK, 8'h5A);
    drain();
    // Stopped timer: zero and out-of-range clock selects.
    cfg_write(REG_CLOCK_SELECT, CFG_W'(8'd0));
    send_item(FUNC_TICK, 8'hA5);
    send_item(FUNC_TICK, 8'h3C);
    cfg_write(REG_CLOCK_SELECT, CFG_W'(8'd255));
    send_item(FUNC_TICK, 8'hFF);
    cfg_write(REG_CLOCK_SELECT, CFG_W'(8'd6));
    cfg_write(REG_COMPARE_VALUE, 16'h0000);
    send_item(FUNC_TICK, 8'h01);
    send_item(FUNC_TICK, 8'h80);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_ECHO, 8'hFF);
    drain();
    cfg_write(REG_COMPARE_VALUE, 16'h8001);
    send_item(FUNC_ECHO, 8'h00);
    drain();
    cfg_write(REG_CLOCK_SELECT, CFG_W'(8'd5));
    cfg_write(REG_COMPARE_VALUE, 16'h0000);
    send_item(FUNC_TICK, 8'h11);
    send_item(FUNC_TICK, 8'h22);
    send_item(FUNC_TICK, 8'h33);
    drain();

    // Fill the store with a match on every tick, overrun it, then read it out
    // while the reply side holds off long enough for the input to back up.
    counting = 1'b1;
    cfg_write(REG_CLOCK_SELECT, CFG_W'(8'd1));
    cfg_write(REG_COMPARE_VALUE, 16'h0000);
    repeat (DEPTH + 4) send_tick();
    long_hold = 1'b1;
    send_item(FUNC_DATA, 8'h00);
    repeat (4) send_item(FUNC_ECHO, SAMPLE_W'($urandom_range(0, 255)));
    send_item(FUNC_DATA, 8'h00);
    repeat (5) send_tick();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= CALM_FROM) calm = 1'b1;
      drain();
      gaps_on = !calm && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          sel = 8'd1;
          cmp = TIMER_W'($urandom_range(0, 1));
        end
        6: begin
          sel = 8'd2;
          cmp = '0;
        end
        7: begin
          sel = SEL_W'($urandom_range(3, 5));
          cmp = TIMER_W'($urandom_range(0, 3));
        end
        8: begin
          sel = ($urandom_range(0, 1) == 0) ? 8'd0 : SEL_W'($urandom_range(6, 255));
          cmp = TIMER_W'($urandom_range(0, 65535));
        end
        default: begin
          sel = 8'd1;
          cmp = ($urandom_range(0, 1) == 0) ? 16'hFFFF : TIMER_W'($urandom_range(2, 65535));
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(REG_CLOCK_SELECT, CFG_W'(sel));
        cfg_write(REG_COMPARE_VALUE, cmp);
      end else begin
        cfg_write(REG_COMPARE_VALUE, cmp);
        cfg_write(REG_CLOCK_SELECT, CFG_W'(sel));
      end

      case (sel)
        8'd1:    div = 1;
        8'd2:    div = 8;
        8'd3:    div = 64;
        8'd4:    div = 256;
        8'd5:    div = 1024;
        default: div = 0;
      endcase
      // Aim near the tick count that just fills the store, sometimes short of it.
      if (div == 0 || cmp > 16'd1000) begin
        n_ticks = $urandom_range(5, 30);
      end else begin
        n_ticks = DEPTH * div * (int'(cmp) + 1) + $urandom_range(0, 6) - 2;
        if (n_ticks > MAX_TICKS) n_ticks = MAX_TICKS;
      end

      for (int i = 0; i < n_ticks && random_items < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(FUNC_ECHO, SAMPLE_W'($urandom_range(0, 255)));
        end else if (r < 5) begin
          send_item(FUNC_UNUSED, SAMPLE_W'($urandom_range(0, 255)));
        end else if (r < 7) begin
          send_item(FUNC_DATA, SAMPLE_W'($urandom_range(0, 255)));
        end else begin
          send_tick();
        end
      end
      send_item(FUNC_DATA, SAMPLE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0) send_item(FUNC_DATA, SAMPLE_W'($urandom_range(0, 255)));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[timed_sample_capture_buffer_unit] OK");
    end else begin
      $display("[timed_sample_capture_buffer_unit] ERROR");
    end
    $finish;
  end

endmodule
